// ===== sv/mrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus RTU response checker.
`timescale 1ns / 1ps
`default_nettype none
package mrc_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 256;
    localparam int DEF_QUEUE_DEPTH     = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_LSB  = 16'h0001;

    // Configuration register indexes.
    localparam logic [1:0] REG_ADDRESS   = 2'd0;
    localparam logic [1:0] REG_FUNCTION  = 2'd1;
    localparam logic [1:0] REG_REG_COUNT = 2'd2;

    localparam logic [7:0] RST_ADDRESS   = 8'd1;
    localparam logic [7:0] RST_FUNCTION  = 8'd4;
    localparam logic [6:0] RST_REG_COUNT = 7'd1;

    // Frame status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_CRC_ERR   = 2'd2;
    localparam logic [1:0] ST_HDR_ERR   = 2'd3;

    // Minimum frame length: address, function, byte count and two CRC bytes.
    localparam int MIN_FRAME_BYTES = 5;

    typedef struct packed {
        logic [7:0] address;
        logic [7:0] fcode;
        logic [6:0] nregs;
    } t_cfg;

    // What one input byte leaves for the output side.
    typedef struct packed {
        logic        word_vld;
        logic [15:0] word;
        logic        stat_vld;
        logic [1:0]  status;
    } t_entry;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_LSB) != 16'h0000) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/mrc_ifs.sv =====
// Handshake channel interfaces: received bytes, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface mrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;
    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrc_out_if;
    logic        valid;
    logic        ready;
    logic        is_status;
    logic [15:0] reg_word;
    logic [1:0]  frame_status;
    logic        last_of_frame;
    modport source (output valid, output is_status, output reg_word, output frame_status,
                    output last_of_frame, input ready);
    modport sink   (input valid, input is_status, input reg_word, input frame_status,
                    input last_of_frame, output ready);
endinterface

interface mrc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/mrc_front.sv =====
// Front end: byte delay line, running CRC, header capture and per-byte result classification.
`timescale 1ns / 1ps
`default_nettype none
module mrc_front #(
    parameter int MAX_FRAME_BYTES = mrc_pkg::DEF_MAX_FRAME_BYTES
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mrc_in_if.sink             i_in,
    input  mrc_pkg::t_cfg      i_cfg,
    input  wire logic          i_q_full,
    output logic               o_push,
    output mrc_pkg::t_entry    o_entry
);
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [15:0]      r_crc, n_crc;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_held0, n_held0, r_held1, n_held1;
    logic [7:0]       r_addr, n_addr, r_func, n_func, r_cnt, n_cnt, r_hi, n_hi;

    logic fire, take, conf, word_vld, fin;
    logic [1:0] status;

    assign i_in.ready = !i_q_full;
    assign fire       = i_in.valid && i_in.ready;
    assign fin        = i_in.frame_end;

    always_comb begin
        take    = r_pos < POS_W'(MAX_FRAME_BYTES);
        conf    = take && (r_pos >= POS_W'(2));
        n_crc   = conf ? mrc_pkg::crc_feed(r_crc, r_held0) : r_crc;
        n_addr  = (conf && r_pos == POS_W'(2)) ? r_held0 : r_addr;
        n_func  = (conf && r_pos == POS_W'(3)) ? r_held0 : r_func;
        n_cnt   = (conf && r_pos == POS_W'(4)) ? r_held0 : r_cnt;
        // Data bytes start at position 5: odd positions carry high bytes, even ones close a word.
        n_hi    = (conf && r_pos[0] && r_pos >= POS_W'(5)) ? r_held0 : r_hi;
        word_vld = conf && !r_pos[0] && (r_pos >= POS_W'(6));
        n_held0 = take ? r_held1 : r_held0;
        n_held1 = take ? i_in.rx_byte : r_held1;
        n_pos   = take ? r_pos + POS_W'(1) : r_pos;

        if (n_pos < POS_W'(mrc_pkg::MIN_FRAME_BYTES)) begin
            status = mrc_pkg::ST_SHORT;
        end else if (n_crc[7:0] != n_held0 || n_crc[15:8] != n_held1) begin
            status = mrc_pkg::ST_CRC_ERR;
        end else if (n_addr != i_cfg.address || n_func != i_cfg.fcode ||
                     n_cnt != {i_cfg.nregs, 1'b0}) begin
            status = mrc_pkg::ST_HDR_ERR;
        end else begin
            status = mrc_pkg::ST_OK;
        end

        o_entry.word_vld = word_vld;
        o_entry.word     = {r_hi, r_held0};
        o_entry.stat_vld = fin;
        o_entry.status   = status;
        o_push           = fire && (word_vld || fin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && fin)) begin
            r_crc   <= mrc_pkg::CRC_INIT;
            r_pos   <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_addr  <= '0;
            r_func  <= '0;
            r_cnt   <= '0;
            r_hi    <= '0;
        end else if (fire) begin
            r_crc   <= n_crc;
            r_pos   <= n_pos;
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_addr  <= n_addr;
            r_func  <= n_func;
            r_cnt   <= n_cnt;
            r_hi    <= n_hi;
        end
    end
endmodule
`default_nettype wire

// ===== sv/mrc_queue.sv =====
// Short FIFO of classified entries between the front end and the result emitter.
`timescale 1ns / 1ps
`default_nettype none
module mrc_queue #(
    parameter int DEPTH = mrc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  mrc_pkg::t_entry i_entry,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_vld,
    output mrc_pkg::t_entry o_head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mrc_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_vld   = r_count != '0;
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/mrc_back.sv =====
// Back end: expands queue entries into word and status results through an output register.
`timescale 1ns / 1ps
`default_nettype none
module mrc_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_vld,
    input  mrc_pkg::t_entry i_q_head,
    output logic            o_pop,
    mrc_out_if.source       o_out
);
    logic        r_vld;
    logic        r_is_status;
    logic [15:0] r_word;
    logic [1:0]  r_status;
    logic        r_last;
    // Set once the word of an entry that also closes the frame is loaded into the output register.
    logic        r_phase;

    logic load, emit_word;

    assign load      = (!r_vld || o_out.ready) && i_q_vld;
    assign emit_word = i_q_head.word_vld && !r_phase;
    assign o_pop     = load && !(emit_word && i_q_head.stat_vld);

    assign o_out.valid         = r_vld;
    assign o_out.is_status     = r_is_status;
    assign o_out.reg_word      = r_word;
    assign o_out.frame_status  = r_status;
    assign o_out.last_of_frame = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_vld   <= 1'b1;
                r_phase <= emit_word && i_q_head.stat_vld;
            end else if (o_out.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_word) begin
                r_is_status <= 1'b0;
                r_word      <= i_q_head.word;
                r_status    <= mrc_pkg::ST_OK;
                r_last      <= 1'b0;
            end else begin
                r_is_status <= 1'b1;
                r_word      <= '0;
                r_status    <= i_q_head.status;
                r_last      <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/modbus_rtu_response_checker_core.sv =====
// Top level of the Modbus RTU read-registers response checker.
//
//   channel   dir   payload                                        beat when
//   i_in      in    rx_byte[7:0], frame_end                        valid && ready
//   o_out     out   is_status, reg_word[15:0], frame_status[1:0],  valid && ready
//                   last_of_frame
//   i_cfg     in    index[1:0], data[7:0]                          valid && ready
//
// One byte is taken per cycle unless the entry queue is full; the CRC update is unrolled over
// eight bits in the front end. Results leave one per cycle from the output register while
// o_out.ready is high; a byte's first result is queued, then loaded into the output register.
// A frame end that also completes a word gives two results, the word and then the status.
// Reset clears the frame state and loads the register defaults; no clearing pass.
// An output stall fills the entry queue; i_in.ready drops only when it is full.
// Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_response_checker_core #(
    parameter int MAX_FRAME_BYTES = mrc_pkg::DEF_MAX_FRAME_BYTES,
    parameter int QUEUE_DEPTH     = mrc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mrc_in_if.sink    i_in,
    mrc_out_if.source o_out,
    mrc_cfg_if.sink   i_cfg
);
    mrc_pkg::t_cfg   r_cfg;
    mrc_pkg::t_entry push_entry, head_entry;
    logic            push, pop, q_full, q_vld;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address <= mrc_pkg::RST_ADDRESS;
            r_cfg.fcode   <= mrc_pkg::RST_FUNCTION;
            r_cfg.nregs   <= mrc_pkg::RST_REG_COUNT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                mrc_pkg::REG_ADDRESS:   r_cfg.address <= i_cfg.data;
                mrc_pkg::REG_FUNCTION:  r_cfg.fcode   <= i_cfg.data;
                mrc_pkg::REG_REG_COUNT: r_cfg.nregs   <= i_cfg.data[6:0];
                default: ;
            endcase
        end
    end

    mrc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_q_full(q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    mrc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(push_entry),
        .i_pop  (pop),
        .o_full (q_full),
        .o_vld  (q_vld),
        .o_head (head_entry)
    );

    mrc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (q_vld),
        .i_q_head(head_entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
`default_nettype wire

// ===== test/modbus_rtu_response_checker_core_test.sv =====
// Self-checking testbench for the Modbus RTU read-registers response checker core.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_response_checker_core_test;

    localparam int FRAME_CAP   = mrc_pkg::DEF_MAX_FRAME_BYTES;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYC  = 8;

    typedef logic [7:0] t_bytes[$];

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_rx_beat;

    typedef struct {
        logic        is_status;
        logic [15:0] word;
        logic [1:0]  status;
        logic        last;
    } t_reply_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrc_in_if  in_ch ();
    mrc_out_if out_ch ();
    mrc_cfg_if cfg_ch ();

    modbus_rtu_response_checker_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_rx_beat   rx_pending[$];
    t_reply_out awaited_reply_out[$];
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit no_idle = 1'b0;

    // Shadow of the configuration registers.
    logic [7:0] want_addr  = mrc_pkg::RST_ADDRESS;
    logic [7:0] want_func  = mrc_pkg::RST_FUNCTION;
    logic [6:0] want_count = mrc_pkg::RST_REG_COUNT;

    // Shadow of the frame state.
    logic [15:0] fr_crc = mrc_pkg::CRC_INIT;
    int unsigned fr_pos = 0;
    logic [7:0]  held[2] = '{8'h00, 8'h00};
    logic [7:0]  got_addr = 8'h00;
    logic [7:0]  got_func = 8'h00;
    logic [7:0]  got_bc = 8'h00;
    logic [7:0]  word_hi = 8'h00;

    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r = r >> 1;
            if (fb) begin
                r = r ^ mrc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic t_bytes with_crc(input t_bytes body);
        t_bytes      full;
        logic [15:0] crc;
        full = body;
        crc = mrc_pkg::CRC_INIT;
        foreach (body[i]) begin
            crc = modbus_crc_byte(crc, body[i]);
        end
        full.push_back(crc[7:0]);
        full.push_back(crc[15:8]);
        return full;
    endfunction

    task automatic log_mismatch(input string what);
        mismatches++;
        $display("%0t: mismatch, %s", $realtime, what);
    endtask

    // Advances the frame shadow by one accepted byte and queues what it produces.
    task automatic track_response_byte(input logic [7:0] b, input logic fin);
        t_reply_out  r;
        int unsigned cidx;
        logic [1:0]  verdict;
        if (fr_pos < FRAME_CAP) begin
            if (fr_pos >= 2) begin
                cidx = fr_pos - 2;
                fr_crc = modbus_crc_byte(fr_crc, held[0]);
                if (cidx == 0) begin
                    got_addr = held[0];
                end else if (cidx == 1) begin
                    got_func = held[0];
                end else if (cidx == 2) begin
                    got_bc = held[0];
                end else if (((cidx - 3) & 1) == 0) begin
                    word_hi = held[0];
                end else begin
                    r = '{1'b0, {word_hi, held[0]}, mrc_pkg::ST_OK, 1'b0};
                    awaited_reply_out.push_back(r);
                end
            end
            held[0] = held[1];
            held[1] = b;
            fr_pos++;
        end
        if (fin) begin
            if (fr_pos < mrc_pkg::MIN_FRAME_BYTES) begin
                verdict = mrc_pkg::ST_SHORT;
            end else if (fr_crc[7:0] != held[0] || fr_crc[15:8] != held[1]) begin
                verdict = mrc_pkg::ST_CRC_ERR;
            end else if (got_addr != want_addr || got_func != want_func ||
                         got_bc != {want_count, 1'b0}) begin
                verdict = mrc_pkg::ST_HDR_ERR;
            end else begin
                verdict = mrc_pkg::ST_OK;
            end
            r = '{1'b1, 16'h0000, verdict, 1'b1};
            awaited_reply_out.push_back(r);
            fr_crc = mrc_pkg::CRC_INIT;
            fr_pos = 0;
            held = '{8'h00, 8'h00};
            got_addr = 8'h00;
            got_func = 8'h00;
            got_bc = 8'h00;
            word_hi = 8'h00;
        end
    endtask

    task automatic queue_bytes(input t_bytes body);
        t_rx_beat beat;
        foreach (body[i]) begin
            beat.data = body[i];
            beat.last = (i == body.size() - 1);
            rx_pending.push_back(beat);
        end
    endtask

    // Builds one random frame against the current configuration.
    task automatic queue_frame(output int unsigned n);
        t_bytes      body;
        int unsigned pick;
        int unsigned ndata;
        logic [7:0]  hdr_addr;
        logic [7:0]  hdr_func;
        logic [7:0]  bc;
        pick = $urandom_range(99);
        hdr_addr = want_addr;
        hdr_func = want_func;
        bc = {want_count, 1'b0};
        ndata = bc;
        if (pick < 6) begin
            repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
        end else if (pick < 12) begin
            repeat ($urandom_range(5, 16)) body.push_back(8'($urandom));
        end else if (pick < 14) begin
            // Runs past the frame limit; the tail is dropped but the end mark still counts.
            repeat ($urandom_range(FRAME_CAP + 1, FRAME_CAP + 8)) body.push_back(8'($urandom));
        end else begin
            if (pick < 24) begin
                case ($urandom_range(2))
                    0: hdr_addr ^= 8'($urandom_range(1, 255));
                    1: hdr_func ^= 8'($urandom_range(1, 255));
                    default: begin
                        bc ^= 8'($urandom_range(1, 255));
                        ndata = $urandom_range(0, 12);
                    end
                endcase
            end else if (pick < 32) begin
                ndata = 2 * $urandom_range(0, 6) + 1;
            end
            body = '{hdr_addr, hdr_func, bc};
            repeat (ndata) body.push_back(8'($urandom));
            body = with_crc(body);
            if (pick >= 32 && pick < 42) begin
                body[$urandom_range(body.size() - 1)] ^= 8'h01 << $urandom_range(7);
            end
        end
        queue_bytes(body);
        n = body.size();
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            mrc_pkg::REG_ADDRESS:   want_addr = val;
            mrc_pkg::REG_FUNCTION:  want_func = val;
            mrc_pkg::REG_REG_COUNT: want_count = val[6:0];
            default: ;
        endcase
    endtask

    // Holds the sender until every queued byte is taken and every result is back.
    // The checks run at the falling edge, once the driver and monitor updates have settled.
    task automatic settle();
        @(negedge i_clk);
        while (rx_pending.size() != 0 || in_ch.valid) @(negedge i_clk);
        while (awaited_reply_out.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic run_phase(input bit load, input logic [7:0] addr, input logic [7:0] func,
                             input logic [6:0] count, input int unsigned budget);
        int unsigned sent;
        int unsigned n;
        if (load) begin
            write_register(mrc_pkg::REG_ADDRESS, addr);
            write_register(mrc_pkg::REG_FUNCTION, func);
            write_register(mrc_pkg::REG_REG_COUNT, {1'b0, count});
        end
        sent = 0;
        while (sent < budget) begin
            queue_frame(n);
            sent += n;
        end
        settle();
    endtask

    // Byte driver; also feeds the shadow on every accepted beat.
    always @(posedge i_clk) begin
        t_rx_beat nxt;
        if (in_ch.valid && in_ch.ready) begin
            track_response_byte(in_ch.rx_byte, in_ch.frame_end);
        end
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (rx_pending.size() != 0 && (no_idle || $urandom_range(99) >= 31)) begin
                nxt = rx_pending.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.rx_byte <= nxt.data;
                in_ch.frame_end <= nxt.last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_reply_out want;
        out_ch.ready <= no_idle || ($urandom_range(99) >= 31);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_reply_out.size() == 0) begin
                log_mismatch($sformatf("unexpected result is_status=%0b word=%h status=%0d last=%0b",
                                       out_ch.is_status, out_ch.reg_word, out_ch.frame_status,
                                       out_ch.last_of_frame));
            end else begin
                want = awaited_reply_out.pop_front();
                if (out_ch.is_status !== want.is_status) begin
                    log_mismatch($sformatf("is_status expected %0b got %0b",
                                           want.is_status, out_ch.is_status));
                end
                if (out_ch.reg_word !== want.word) begin
                    log_mismatch($sformatf("reg_word expected %h got %h",
                                           want.word, out_ch.reg_word));
                end
                if (out_ch.frame_status !== want.status) begin
                    log_mismatch($sformatf("frame_status expected %0d got %0d",
                                           want.status, out_ch.frame_status));
                end
                if (out_ch.last_of_frame !== want.last) begin
                    log_mismatch($sformatf("last_of_frame expected %0b got %0b",
                                           want.last, out_ch.last_of_frame));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.rx_byte = 8'h00;
        in_ch.frame_end = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mrc_pkg::REG_ADDRESS;
        cfg_ch.data = 8'h00;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Frames of one and four bytes are too short.
        queue_bytes('{8'hFF});
        queue_bytes('{8'h00, 8'hFF, 8'h00, 8'hFF});
        // The last byte completes a word and closes the frame in the same beat.
        queue_bytes(with_crc('{8'h01, 8'h04, 8'h02, 8'hFF, 8'h00}));
        // Minimum length, but the byte count does not match.
        queue_bytes(with_crc('{8'h01, 8'h04, 8'h00}));
        // One unpaired data byte gives no word.
        queue_bytes(with_crc('{8'h01, 8'h04, 8'h02, 8'hAA}));
        settle();

        run_phase(1'b0, mrc_pkg::RST_ADDRESS, mrc_pkg::RST_FUNCTION, mrc_pkg::RST_REG_COUNT,
                  140);
        run_phase(1'b1, 8'h00, 8'h03, 7'd2, 150);
        run_phase(1'b1, 8'hFF, 8'hFF, 7'd127, 200);
        no_idle = 1'b1;
        run_phase(1'b1, 8'($urandom), 8'h04, 7'd0, 140);
        no_idle = 1'b0;
        run_phase(1'b1, 8'($urandom), 8'($urandom), 7'($urandom_range(1, 6)), 150);
        run_phase(1'b1, 8'h7F, 8'h80, 7'd3, 140);

        if (awaited_reply_out.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", awaited_reply_out.size()));
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
